>>> hw/rtl/http_request_line_tokenizer_assert.svh
// Assertion macros used by the checker file of the line tokenizer.
`ifndef HTTP_REQUEST_LINE_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_LINE_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTOK_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTOK_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

>>> hw/rtl/htok_pkg.sv
// Shared codes, character constants and the method table of the line tokenizer.
package htok_pkg;

  localparam int START_W = 13;
  localparam int LEN_W   = 14;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FEW_TOKENS = 3'd1,
    ST_BAD_METHOD = 3'd2,
    ST_NO_KEY     = 3'd3,
    ST_NO_VALUE   = 3'd4,
    ST_TOO_LONG   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    METH_GET    = 2'd0,
    METH_POST   = 2'd1,
    METH_PUT    = 2'd2,
    METH_DELETE = 2'd3
  } method_t;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [2:0] METH_LEN [4] = '{3'd3, 3'd4, 3'd3, 3'd6};

  typedef struct packed {
    status_t                status;
    method_t                method_code;
    logic [START_W-1:0]     first_start;
    logic [LEN_W-1:0]       first_length;
    logic [START_W-1:0]     second_start;
    logic [LEN_W-1:0]       second_length;
    logic [START_W-1:0]     third_start;
    logic [LEN_W-1:0]       third_length;
  } result_t;

  // Character at position k of the method name m, zero past its end.
  function automatic logic [7:0] meth_char(input method_t m, input logic [2:0] k);
    logic [47:0] txt;
    logic [7:0]  c;
    txt = '0;
    c   = 8'h00;
    unique case (m)
      METH_GET:    txt = {"GET", 24'h0};
      METH_POST:   txt = {"POST", 16'h0};
      METH_PUT:    txt = {"PUT", 24'h0};
      METH_DELETE: txt = "DELETE";
      default:     txt = '0;
    endcase
    case (k)
      3'd0:    c = txt[47:40];
      3'd1:    c = txt[39:32];
      3'd2:    c = txt[31:24];
      3'd3:    c = txt[23:16];
      3'd4:    c = txt[15:8];
      3'd5:    c = txt[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/htok_if.sv
// Byte and result channel interfaces of the line tokenizer.
interface htok_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       header_mode;
  logic       line_end;

  modport source (output valid, line_byte, header_mode, line_end, input ready);
  modport sink (input valid, line_byte, header_mode, line_end, output ready);
endinterface

interface htok_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  method_code;
  logic [12:0] first_start;
  logic [13:0] first_length;
  logic [12:0] second_start;
  logic [13:0] second_length;
  logic [12:0] third_start;
  logic [13:0] third_length;

  modport source (output valid, status, method_code, first_start, first_length,
                  second_start, second_length, third_start, third_length,
                  input ready);
  modport sink (input valid, status, method_code, first_start, first_length,
                second_start, second_length, third_start, third_length,
                output ready);
endinterface

>>> hw/rtl/htok_front.sv
// Front end: takes one byte per cycle while the queue has room, tracks tokens and emits a line summary.
module htok_front #(
  parameter int MAX_LINE = 8192,
  parameter int PosW     = 14,
  parameter int SumW     = 8 * PosW + 8
) (
  input  logic            clk,
  input  logic            rst,
  htok_byte_if.sink       bytes,
  output logic            push_valid,
  input  logic            push_ready,
  output logic [SumW-1:0] push_data
);
  import htok_pkg::*;

  typedef struct packed {
    logic                   hdr;
    logic                   ovf;
    logic [3:0]             mask;
    logic [1:0]             count;
    logic [PosW-1:0]        ce;
    logic [PosW-1:0]        vs;
    logic [2:0][PosW-1:0]   starts;
    logic [2:0][PosW-1:0]   ends;
  } line_sum_t;

  localparam logic [PosW-1:0] LimitPos = PosW'(MAX_LINE);

  logic [PosW-1:0]      pos, pos_next;
  logic [PosW-1:0]      ce, ce_next;
  logic [PosW-1:0]      vs, vs_next;
  logic [1:0]           count, count_next;
  logic                 in_tok, in_tok_next;
  logic                 skip, skip_next;
  logic [2:0][PosW-1:0] starts, starts_next;
  logic [2:0][PosW-1:0] ends, ends_next, ends_fin;
  logic [3:0]           mask, mask_next;
  logic                 ovf, ovf_next;
  logic [2:0]           mk, mk_next;
  logic                 accept;
  logic                 is_sp, delim;
  line_sum_t            sum;

  assign bytes.ready = push_ready;
  assign accept      = bytes.valid && bytes.ready;

  always_comb begin
    pos_next    = pos;
    ce_next     = ce;
    vs_next     = vs;
    count_next  = count;
    in_tok_next = in_tok;
    skip_next   = skip;
    starts_next = starts;
    ends_next   = ends;
    mask_next   = mask;
    ovf_next    = ovf;
    mk_next     = mk;
    is_sp = (bytes.line_byte == CH_SP) || (bytes.line_byte == CH_TAB);
    delim = bytes.header_mode ? (bytes.line_byte == CH_COLON) : is_sp;
    if (pos == LimitPos) begin
      ovf_next = 1'b1;
    end else begin
      pos_next = pos + 1'b1;
      if (bytes.line_byte != CH_CR && bytes.line_byte != CH_LF) begin
        ce_next = pos + 1'b1;
      end
      if (delim) begin
        if (in_tok && count != 2'd0) begin
          ends_next[2'(count - 2'd1)] = pos;
        end
        in_tok_next = 1'b0;
        skip_next   = 1'b0;
      end else if (in_tok || count != 2'd3) begin
        if (!in_tok) begin
          starts_next[count] = pos;
          count_next         = count + 2'd1;
          in_tok_next        = 1'b1;
          skip_next          = bytes.header_mode && (count == 2'd1);
          if (count == 2'd1) begin
            vs_next = pos;
          end
        end
        if (skip_next) begin
          if (is_sp) begin
            vs_next = pos + 1'b1;
          end else begin
            skip_next = 1'b0;
          end
        end
        if (count_next == 2'd1) begin
          for (int j = 0; j < 4; j++) begin
            if (mk >= METH_LEN[j] ||
                meth_char(method_t'(2'(j)), mk) != bytes.line_byte) begin
              mask_next[j] = 1'b0;
            end
          end
          mk_next = (mk == 3'd7) ? mk : mk + 3'd1;
        end
      end
    end
    ends_fin = ends_next;
    if (in_tok_next && count_next != 2'd0) begin
      ends_fin[2'(count_next - 2'd1)] = pos_next;
    end
  end

  always_comb begin
    sum.hdr    = bytes.header_mode;
    sum.ovf    = ovf_next;
    sum.mask   = mask_next;
    sum.count  = count_next;
    sum.ce     = ce_next;
    sum.vs     = vs_next;
    sum.starts = starts_next;
    sum.ends   = ends_fin;
  end

  assign push_valid = accept && bytes.line_end;
  assign push_data  = sum;

  always_ff @(posedge clk) begin
    if (rst || (accept && bytes.line_end)) begin
      pos    <= '0;
      ce     <= '0;
      vs     <= '0;
      count  <= '0;
      in_tok <= 1'b0;
      skip   <= 1'b0;
      starts <= '0;
      ends   <= '0;
      mask   <= 4'hF;
      ovf    <= 1'b0;
      mk     <= '0;
    end else if (accept) begin
      pos    <= pos_next;
      ce     <= ce_next;
      vs     <= vs_next;
      count  <= count_next;
      in_tok <= in_tok_next;
      skip   <= skip_next;
      starts <= starts_next;
      ends   <= ends_next;
      mask   <= mask_next;
      ovf    <= ovf_next;
      mk     <= mk_next;
    end
  end

endmodule

>>> hw/rtl/htok_queue.sv
// Two-entry queue of line summaries between the front and back ends.
module htok_queue #(
  parameter int Width = 120
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [Width-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [Width-1:0] pop_data
);

  logic [Width-1:0] slots [2];
  logic             wp, rp;
  logic [1:0]       fill;
  logic             do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slots[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        slots[wp] <= push_data;
        wp        <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> hw/rtl/htok_back.sv
// Back end: clamps token bounds, checks the method and registers the result.
module htok_back #(
  parameter int PosW = 14,
  parameter int SumW = 8 * PosW + 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  logic [SumW-1:0] pop_data,
  htok_result_if.source   results
);
  import htok_pkg::*;

  typedef struct packed {
    logic                   hdr;
    logic                   ovf;
    logic [3:0]             mask;
    logic [1:0]             count;
    logic [PosW-1:0]        ce;
    logic [PosW-1:0]        vs;
    logic [2:0][PosW-1:0]   starts;
    logic [2:0][PosW-1:0]   ends;
  } line_sum_t;

  line_sum_t            sum;
  logic [1:0]           n_c;
  logic                 brk;
  logic [PosW-1:0]      e_tmp;
  logic [2:0][PosW-1:0] st_c, en_c;

  logic                 s1_valid;
  logic                 s1_hdr, s1_ovf;
  logic [3:0]           s1_mask;
  logic [1:0]           s1_n;
  logic [PosW-1:0]      s1_vs;
  logic [2:0][PosW-1:0] s1_st, s1_en;
  logic                 s1_ready;

  logic [2:0][PosW-1:0] len;
  logic [PosW-1:0]      vs_c;
  logic                 found;
  method_t              code;
  result_t              res;
  result_t              out_item;
  logic                 out_valid;
  logic                 out_ld;

  assign sum = pop_data;

  always_comb begin
    n_c   = 2'd0;
    brk   = 1'b0;
    e_tmp = '0;
    st_c  = '0;
    en_c  = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < sum.count && !brk) begin
        if (sum.starts[i] >= sum.ce) begin
          brk = 1'b1;
        end else begin
          n_c = n_c + 2'd1;
        end
      end
      st_c[i] = sum.starts[i];
      e_tmp   = (sum.ends[i] > sum.ce) ? sum.ce : sum.ends[i];
      en_c[i] = (e_tmp < sum.starts[i]) ? sum.starts[i] : e_tmp;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      len[i] = s1_en[i] - s1_st[i];
    end
    vs_c  = (s1_vs > s1_en[1]) ? s1_en[1] : s1_vs;
    found = 1'b0;
    code  = METH_GET;
    for (int j = 3; j >= 0; j--) begin
      if (s1_mask[j] && len[0] == PosW'(METH_LEN[j])) begin
        found = 1'b1;
        code  = method_t'(2'(j));
      end
    end
    res = '0;
    if (s1_ovf) begin
      res.status = ST_TOO_LONG;
    end else if (!s1_hdr) begin
      if (s1_n != 2'd3) begin
        res.status = ST_FEW_TOKENS;
      end else if (!found) begin
        res.status = ST_BAD_METHOD;
      end else begin
        res.status        = ST_OK;
        res.method_code   = code;
        res.first_start   = START_W'(s1_st[0]);
        res.first_length  = LEN_W'(len[0]);
        res.second_start  = START_W'(s1_st[1]);
        res.second_length = LEN_W'(len[1]);
        res.third_start   = START_W'(s1_st[2]);
        res.third_length  = LEN_W'(len[2]);
      end
    end else begin
      if (s1_n == 2'd0) begin
        res.status = ST_NO_KEY;
      end else if (s1_n == 2'd1) begin
        res.status = ST_NO_VALUE;
      end else begin
        res.status        = ST_OK;
        res.first_start   = START_W'(s1_st[0]);
        res.first_length  = LEN_W'(len[0]);
        res.second_start  = START_W'(vs_c);
        res.second_length = LEN_W'(s1_en[1] - vs_c);
      end
    end
  end

  assign out_ld    = !out_valid || results.ready;
  assign s1_ready  = !s1_valid || out_ld;
  assign pop_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pop_valid;
        if (pop_valid) begin
          s1_hdr  <= sum.hdr;
          s1_ovf  <= sum.ovf;
          s1_mask <= sum.mask;
          s1_n    <= n_c;
          s1_vs   <= sum.vs;
          s1_st   <= st_c;
          s1_en   <= en_c;
        end
      end
      if (out_ld) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          out_item <= res;
        end
      end
    end
  end

  assign results.valid         = out_valid;
  assign results.status        = out_item.status;
  assign results.method_code   = out_item.method_code;
  assign results.first_start   = out_item.first_start;
  assign results.first_length  = out_item.first_length;
  assign results.second_start  = out_item.second_start;
  assign results.second_length = out_item.second_length;
  assign results.third_start   = out_item.third_start;
  assign results.third_length  = out_item.third_length;

endmodule

>>> hw/rtl/http_request_line_tokenizer.sv
// Top level of the HTTP request line and header line tokenizer.
//
//   channel   direction  request
//   bytes     in         one byte of a line, mode flag, last-byte mark
//   results   out        status, method code, three token offsets and lengths
//
// One byte is taken per cycle while the summary queue has room.
// The summary of a line passes from the edge that takes its last byte
// through a two-entry summary queue, a clamp stage and the output register.
// A stalled result stops the byte input only once four lines wait in the
// queue, the clamp stage and the output register.
// Reset is synchronous and clears the line state and all handshakes.
module http_request_line_tokenizer #(
  parameter int MAX_LINE = 8192
) (
  input  logic          clk,
  input  logic          rst,
  htok_byte_if.sink     bytes,
  htok_result_if.source results
);

  localparam int PosW = $clog2(MAX_LINE + 1);
  localparam int SumW = 8 * PosW + 8;

  logic            f_valid, f_ready;
  logic [SumW-1:0] f_data;
  logic            b_valid, b_ready;
  logic [SumW-1:0] b_data;

  htok_front #(
    .MAX_LINE (MAX_LINE),
    .PosW     (PosW),
    .SumW     (SumW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  htok_queue #(
    .Width (SumW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  htok_back #(
    .PosW (PosW),
    .SumW (SumW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data),
    .results   (results)
  );

endmodule

>>> hw/rtl/htok_checker.sv
// Port-level assertion checker of the line tokenizer and its bind.
`include "http_request_line_tokenizer_assert.svh"

module htok_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_line_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [1:0]  out_method_code,
  input logic [12:0] out_first_start,
  input logic [13:0] out_second_length
);
  import htok_pkg::*;

  logic [2:0] pending;
  logic       line_in, line_out;

  assign line_in  = in_valid && in_ready && in_line_end;
  assign line_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'b0, line_in} - {2'b0, line_out};
    end
  end

  `HTOK_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_status))
  `HTOK_ASSERT_NOW(a_no_phantom, clk, rst, out_valid, pending != 3'd0)
  `HTOK_ASSERT_NOW(a_err_zero, clk, rst, out_valid && out_status != ST_OK, out_method_code == 2'd0 && out_first_start == 13'd0 && out_second_length == 14'd0)
  `HTOK_ASSERT_NOW(a_bounded, clk, rst, 1'b1, pending <= 3'd4)

endmodule

bind http_request_line_tokenizer htok_checker u_htok_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (bytes.valid),
  .in_ready          (bytes.ready),
  .in_line_end       (bytes.line_end),
  .out_valid         (results.valid),
  .out_ready         (results.ready),
  .out_status        (results.status),
  .out_method_code   (results.method_code),
  .out_first_start   (results.first_start),
  .out_second_length (results.second_length)
);
